// ===== design/stun_binding_response_parser_core_macros.svh =====
// Assertion macros for the STUN binding response parser checker.
// Included by the checker file; no other dependencies.
`ifndef STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH
`define STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rstn is low.
`define SBRP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbrp checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rstn is low.
`define SBRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbrp checker: next-cycle property failed");

`endif

// ===== design/sbrp_pkg.sv =====
// Shared constants, types and header-byte lookup for the STUN parser.
// No dependencies.
package sbrp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 512;
    localparam int unsigned OFFSET_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned POS_W = 17;

    localparam logic [15:0] STUN_TYPE_SUCCESS = 16'h0101;
    localparam logic [31:0] STUN_COOKIE       = 32'h2112A442;
    localparam logic [15:0] ATTR_MAPPED       = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED   = 16'h0020;
    localparam logic [7:0]  FAMILY_IPV4       = 8'h01;
    localparam logic [4:0]  HEADER_BYTES      = 5'd20;

    typedef enum logic {
        CFG_TXID_UPPER = 1'b0,
        CFG_TXID_LOWER = 1'b1
    } cfg_index_t;

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [POS_W-1:0]    pos_t;

    function automatic logic [7:0] expected_header_byte(
        input logic [4:0]  o,
        input logic [31:0] txid_upper,
        input logic [63:0] txid_lower
    );
        logic [4:0] sel_cookie;
        logic [4:0] sel_upper;
        logic [4:0] sel_lower;
        logic [7:0] result;
        sel_cookie = 5'd7 - o;
        sel_upper  = 5'd11 - o;
        sel_lower  = 5'd19 - o;
        if (o == 5'd0) begin
            result = STUN_TYPE_SUCCESS[15:8];
        end else if (o == 5'd1) begin
            result = STUN_TYPE_SUCCESS[7:0];
        end else if (o >= 5'd4 && o < 5'd8) begin
            result = STUN_COOKIE[{sel_cookie[1:0], 3'b000} +: 8];
        end else if (o >= 5'd8 && o < 5'd12) begin
            result = txid_upper[{sel_upper[1:0], 3'b000} +: 8];
        end else begin
            result = txid_lower[{sel_lower[2:0], 3'b000} +: 8];
        end
        return result;
    endfunction

endpackage

// ===== design/stun_binding_response_parser_core.sv =====
// STUN binding response parser: streams datagram bytes, returns mapped address.
// Depends on sbrp_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  cfg     | in  | cfg_we            | cfg_index, cfg_data (txid registers)
//  s_      | in  | s_valid / s_ready | s_rx_byte, s_last_byte
//  m_      | out | m_valid / m_ready | m_resolved, m_external_ip, m_external_port
//
// One word per cycle sustained while s_ready is high; packet state updates in the accepting cycle.
// The result of a packet is registered and shows in the cycle after its last word is accepted.
// s_ready drops only while a result waits and m_ready is low.
// Reset (aresetn low, synchronous) clears packet state and the txid registers.
module stun_binding_response_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_resolved,
    output logic [31:0] m_external_ip,
    output logic [15:0] m_external_port
);
    import sbrp_pkg::*;

    logic [31:0] txid_upper_reg;
    logic [63:0] txid_lower_reg;

    offset_t     byte_offset_reg,      byte_offset_next;
    logic        header_good_reg,      header_good_next;
    pos_t        attribute_start_reg,  attribute_start_next;
    logic [15:0] attribute_kind_reg,   attribute_kind_next;
    logic [15:0] attribute_length_reg, attribute_length_next;
    logic        family_good_reg,      family_good_next;
    logic [31:0] captured_address_reg, captured_address_next;
    logic [15:0] captured_port_reg,    captured_port_next;
    logic        pending_match_reg,    pending_match_next;
    pos_t        pending_end_reg,      pending_end_next;
    logic        walk_finished_reg,    walk_finished_next;

    logic        m_valid_reg;
    logic        m_resolved_reg;
    logic [31:0] m_external_ip_reg;
    logic [15:0] m_external_port_reg;

    logic        accept;
    logic        packet_ok;
    offset_t     rel;
    pos_t        body_span;
    logic [15:0] len_full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        byte_offset_next      = byte_offset_reg;
        header_good_next      = header_good_reg;
        attribute_start_next  = attribute_start_reg;
        attribute_kind_next   = attribute_kind_reg;
        attribute_length_next = attribute_length_reg;
        family_good_next      = family_good_reg;
        captured_address_next = captured_address_reg;
        captured_port_next    = captured_port_reg;
        pending_match_next    = pending_match_reg;
        pending_end_next      = pending_end_reg;
        walk_finished_next    = walk_finished_reg;
        rel       = byte_offset_reg - attribute_start_reg[OFFSET_W-1:0];
        len_full  = {attribute_length_reg[15:8], s_rx_byte};
        body_span = (POS_W'({1'b0, len_full}) + POS_W'(3)) & ~POS_W'(3);

        if (byte_offset_reg < offset_t'(MAX_PACKET_BYTES)) begin
            if (byte_offset_reg < offset_t'(HEADER_BYTES)) begin
                if (byte_offset_reg != offset_t'(2) && byte_offset_reg != offset_t'(3) &&
                    s_rx_byte != expected_header_byte(byte_offset_reg[4:0],
                                                      txid_upper_reg, txid_lower_reg)) begin
                    header_good_next = 1'b0;
                end
            end else if (!walk_finished_reg &&
                         POS_W'(byte_offset_reg) >= attribute_start_reg) begin
                if (rel == offset_t'(0)) begin
                    attribute_kind_next = {s_rx_byte, 8'h00};
                end else if (rel == offset_t'(1)) begin
                    attribute_kind_next = {attribute_kind_reg[15:8], s_rx_byte};
                end else if (rel == offset_t'(2)) begin
                    attribute_length_next = {s_rx_byte, 8'h00};
                end else if (rel == offset_t'(3)) begin
                    attribute_length_next = len_full;
                    family_good_next      = 1'b0;
                    pending_end_next      = attribute_start_reg + POS_W'(4) + body_span;
                    if (!((attribute_kind_reg == ATTR_XOR_MAPPED ||
                           attribute_kind_reg == ATTR_MAPPED) && len_full >= 16'd8)) begin
                        attribute_start_next = attribute_start_reg + POS_W'(4) + body_span;
                    end
                end else if (rel == offset_t'(5)) begin
                    family_good_next = (s_rx_byte == FAMILY_IPV4);
                end else if (rel == offset_t'(6) || rel == offset_t'(7)) begin
                    captured_port_next = {captured_port_reg[7:0], s_rx_byte};
                end else if (rel >= offset_t'(8) && rel <= offset_t'(11)) begin
                    captured_address_next = {captured_address_reg[23:0], s_rx_byte};
                    if (rel == offset_t'(11)) begin
                        if (family_good_reg) begin
                            if (attribute_kind_reg == ATTR_XOR_MAPPED) begin
                                captured_port_next    = captured_port_reg ^ STUN_COOKIE[31:16];
                                captured_address_next = {captured_address_reg[23:0], s_rx_byte}
                                                        ^ STUN_COOKIE;
                            end
                            pending_match_next = 1'b1;
                            walk_finished_next = 1'b1;
                        end else begin
                            attribute_start_next = pending_end_reg;
                        end
                    end
                end
            end
            byte_offset_next = byte_offset_reg + offset_t'(1);
        end

        packet_ok = header_good_next && byte_offset_next >= offset_t'(HEADER_BYTES) &&
                    pending_match_next && pending_end_next <= POS_W'(byte_offset_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txid_upper_reg <= '0;
            txid_lower_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TXID_UPPER: txid_upper_reg <= cfg_data[31:0];
                CFG_TXID_LOWER: txid_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            byte_offset_reg      <= '0;
            header_good_reg      <= 1'b1;
            attribute_start_reg  <= POS_W'(HEADER_BYTES);
            attribute_kind_reg   <= '0;
            attribute_length_reg <= '0;
            family_good_reg      <= 1'b0;
            captured_address_reg <= '0;
            captured_port_reg    <= '0;
            pending_match_reg    <= 1'b0;
            pending_end_reg      <= '0;
            walk_finished_reg    <= 1'b0;
        end else if (accept) begin
            byte_offset_reg      <= byte_offset_next;
            header_good_reg      <= header_good_next;
            attribute_start_reg  <= attribute_start_next;
            attribute_kind_reg   <= attribute_kind_next;
            attribute_length_reg <= attribute_length_next;
            family_good_reg      <= family_good_next;
            captured_address_reg <= captured_address_next;
            captured_port_reg    <= captured_port_next;
            pending_match_reg    <= pending_match_next;
            pending_end_reg      <= pending_end_next;
            walk_finished_reg    <= walk_finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            m_resolved_reg      <= packet_ok;
            m_external_ip_reg   <= packet_ok ? captured_address_next : 32'd0;
            m_external_port_reg <= packet_ok ? captured_port_next : 16'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_resolved      = m_resolved_reg;
    assign m_external_ip   = m_external_ip_reg;
    assign m_external_port = m_external_port_reg;

endmodule

// ===== design/sbrp_checker.sv =====
// Port-level checker for the STUN binding response parser, bound to the top.
// Depends on stun_binding_response_parser_core_macros.svh.
`include "stun_binding_response_parser_core_macros.svh"

module sbrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_resolved,
    input logic [31:0] m_external_ip,
    input logic [15:0] m_external_port
);

    `SBRP_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_resolved) && $stable(m_external_ip) && $stable(m_external_port))
    `SBRP_ASSERT_NOW(a_zero_unresolved, aclk, aresetn, m_valid && !m_resolved, m_external_ip == 32'd0 && m_external_port == 16'd0)
    `SBRP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, s_valid && s_ready && s_last_byte, m_valid)
    `SBRP_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `SBRP_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn, (!m_valid || m_ready) && !(s_valid && s_ready && s_last_byte), !m_valid)

endmodule

bind stun_binding_response_parser_core sbrp_checker u_sbrp_checker (.*);
